FILE: rtl/core/bgws_pkg.sv
// Shared types and constants for the grid warp sampler.
`timescale 1ns / 1ps
package bgws_pkg;
  typedef enum logic [1:0] {
    FUNC_LOAD_X = 2'd0,
    FUNC_LOAD_Y = 2'd1,
    FUNC_LOAD_D = 2'd2,
    FUNC_SAMPLE = 2'd3
  } func_t;

  localparam int unsigned REG_X_POINTS    = 0;
  localparam int unsigned REG_Y_POINTS    = 1;
  localparam int unsigned MAX_AXIS_POINTS = 16;
  localparam int unsigned WEIGHT_ONE      = 65536;
  localparam int unsigned WEIGHT_SHIFT    = 16;
  localparam int unsigned SNAP_LSB        = 6;
  localparam int unsigned DEFORM_DEPTH    = 256;

  typedef struct packed {
    func_t       func;
    logic [7:0]  slot;
    logic [31:0] value_x;
    logic [31:0] value_y;
  } cmd_t;

  typedef struct packed {
    logic        valid_res;
    logic [3:0]  cell_col;
    logic [3:0]  cell_row;
    logic [16:0] weight_u;
    logic [16:0] weight_v;
    logic [31:0] warped_x;
    logic [31:0] warped_y;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SRCH, ST_DIV, ST_DFRD, ST_DFWT, ST_MUL, ST_DONE
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction
endpackage

FILE: rtl/core/bgws_if.sv
// Valid/ready channel carrying one payload type.
`timescale 1ns / 1ps
interface bgws_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/bilinear_grid_warp_sampler.sv
// Top level of the bilinear grid warp sampler.
//   channel  dir  payload
//   in_ch    in   func, slot, value_x, value_y
//   out_ch   out  valid_res, cell_col, cell_row, weights, warped, offset
//   cfg      in   we / index / wdata (x_points, y_points)
// A load is handled in the idle state; a sample with too few points goes straight to done.
// A full sample runs: pop, a search of each axis, a shift-subtract divide per axis,
// reads of the four deformation corners, 24 multiply-accumulate steps on one multiplier
// and a done state that posts the result.
// After reset every deformation store entry is cleared before the back runs.
// The two-deep queue lets the front accept while the back works; a sample is not
// taken while an earlier result still waits on out_ch.
`timescale 1ns / 1ps
module bilinear_grid_warp_sampler
  import bgws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  bgws_if.sink        in_ch,
  bgws_if.source      out_ch
);
  logic [4:0] x_points, y_points;
  always_ff @(posedge clk) begin
    if (rst) begin
      x_points <= 5'd2;
      y_points <= 5'd2;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_X_POINTS)) x_points <= cfg_wdata;
      if (cfg_index == 1'(REG_Y_POINTS)) y_points <= cfg_wdata;
    end
  end

  logic push, full, pop, empty;
  cmd_t wcmd, rcmd;
  bgws_front u_front (.clk, .rst, .in_ch, .push, .cmd(wcmd), .full);
  bgws_fifo u_fifo (.clk, .rst, .push, .wdata(wcmd), .full, .pop, .empty, .rdata(rcmd));
  bgws_back u_back (
    .clk, .rst, .x_points, .y_points, .empty, .cmd(rcmd), .pop, .out_ch);

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");
endmodule

FILE: rtl/core/bgws_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bgws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/bgws_fifo.sv
// Two-entry command queue between the front and the back.
`timescale 1ns / 1ps
module bgws_fifo
  import bgws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rdata
);
  cmd_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = q[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) q[wp] <= wdata;
  end
endmodule

FILE: rtl/core/bgws_front.sv
// Front end: accepts items, drops out-of-range axis loads, queues the rest.
`timescale 1ns / 1ps
module bgws_front
  import bgws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bgws_if.sink in_ch,
  output logic push,
  output cmd_t cmd,
  input  logic full
);
  logic acc, drop;
  assign in_ch.ready = !full;
  assign acc = in_ch.valid && in_ch.ready;
  assign cmd = '{func: func_t'(in_ch.data.func), slot: in_ch.data.slot,
                 value_x: in_ch.data.value_x, value_y: in_ch.data.value_y};
  always_comb begin
    unique case (func_t'(in_ch.data.func))
      FUNC_LOAD_X, FUNC_LOAD_Y: drop = 32'(in_ch.data.slot) >= MAX_AXIS_POINTS;
      default: drop = 1'b0;
    endcase
  end
  assign push = acc && !drop;
  logic unused;
  assign unused = clk ^ rst;
endmodule

FILE: rtl/core/bgws_divider.sv
// Restoring divider: quotient of a 49-bit numerator by a 33-bit span, 1 bit/cycle.
`timescale 1ns / 1ps
module bgws_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [48:0] num,
  input  logic [32:0] den,
  output logic        busy,
  output logic [48:0] quo
);
  logic [33:0] rem;
  logic [48:0] q;
  logic [5:0]  cnt;
  logic [33:0] trial;
  assign trial = {rem[32:0], q[48]} - {1'b0, den};
  assign quo = q;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd49;
      rem <= '0;
      q <= num;
    end else if (busy) begin
      if (trial[33]) begin
        rem <= {rem[32:0], q[48]};
        q <= {q[47:0], 1'b0};
      end else begin
        rem <= trial;
        q <= {q[47:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule

FILE: rtl/core/bgws_back.sv
// Back end: table writes, axis search, weights and bilinear blend.
`timescale 1ns / 1ps
module bgws_back
  import bgws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [4:0] x_points,
  input  logic [4:0] y_points,
  input  logic       empty,
  input  cmd_t       cmd,
  output logic       pop,
  bgws_if.source     out_ch
);
  localparam int AW = $clog2(MAX_AXIS_POINTS);
  localparam int DW = $clog2(DEFORM_DEPTH);

  state_t state, state_next;
  logic [31:0] ax [MAX_AXIS_POINTS];
  logic [31:0] ay [MAX_AXIS_POINTS];
  logic [DW-1:0] clr_addr;
  logic out_valid;
  res_t res;

  // sample working state
  logic [AW:0] nx, ny;
  logic [AW-1:0] idx_i;
  logic axis_sel;
  logic [AW-1:0] cx, cy;
  logic signed [32:0] px, py;
  logic [16:0] u, v;
  logic [1:0] corner;
  logic signed [31:0] dfx [4];
  logic signed [31:0] dfy [4];
  logic [2:0] mstep;
  logic signed [63:0] acc;
  logic signed [63:0] r0, r1, bx, by, wx;

  // divider
  logic div_start, div_busy, div_pend;
  logic [48:0] div_num, div_quo;
  logic [32:0] div_den;
  bgws_divider u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
                      .busy(div_busy), .quo(div_quo));

  // deformation stores
  logic dwe;
  logic [DW-1:0] dwaddr, draddr;
  logic [31:0] dwx, dwy, drx, dry;
  bgws_ram #(.WIDTH(32), .DEPTH(DEFORM_DEPTH)) u_dx (.clk, .we(dwe), .waddr(dwaddr),
    .wdata(dwx), .raddr(draddr), .rdata(drx));
  bgws_ram #(.WIDTH(32), .DEPTH(DEFORM_DEPTH)) u_dy (.clk, .we(dwe), .waddr(dwaddr),
    .wdata(dwy), .raddr(draddr), .rdata(dry));

  // current axis view
  logic [AW:0] n_cur;
  logic signed [32:0] p_cur, lo, hi, pcl, a_i1, a_i, span;
  logic [AW-1:0] last_i;
  assign n_cur = axis_sel ? ny : nx;
  assign p_cur = axis_sel ? py : px;
  assign last_i = AW'(n_cur - 2);
  assign lo = axis_sel ? 33'(signed'(ay[0])) : 33'(signed'(ax[0]));
  assign hi = axis_sel ? 33'(signed'(ay[AW'(n_cur-1)])) : 33'(signed'(ax[AW'(n_cur-1)]));
  assign pcl = (p_cur < lo) ? lo : (p_cur > hi) ? hi : p_cur;
  assign a_i1 = axis_sel ? 33'(signed'(ay[AW'(idx_i+1)])) : 33'(signed'(ax[AW'(idx_i+1)]));
  assign a_i = axis_sel ? 33'(signed'(ay[idx_i])) : 33'(signed'(ax[idx_i]));
  assign span = a_i1 - a_i;

  logic signed [33:0] numd;
  assign numd = 34'(pcl) - 34'(a_i);

  function automatic logic [16:0] snap(input logic [48:0] q);
    logic [48:0] c;
    c = (q > 49'(WEIGHT_ONE)) ? 49'(WEIGHT_ONE) : q;
    if (c <= 49'(SNAP_LSB)) return 17'd0;
    if (c >= 49'(WEIGHT_ONE - SNAP_LSB)) return 17'(WEIGHT_ONE);
    return c[16:0];
  endfunction

  // vertex index for a corner
  logic [AW-1:0] ccol, crow;
  logic [2*AW+1:0] vidx;
  assign ccol = cx + AW'(corner[0]);
  assign crow = cy + AW'(corner[1]);
  assign vidx = (2*AW+2)'(crow) * (2*AW+2)'(nx) + (2*AW+2)'(ccol);

  // multiply step: one product per cycle
  logic signed [33:0] mop;
  logic signed [17:0] mw;
  logic signed [63:0] prod;
  logic signed [31:0] ux0, ux1, uy0, uy1;
  assign ux0 = ax[cx];
  assign ux1 = ax[AW'(cx+1)];
  assign uy0 = ay[cy];
  assign uy1 = ay[AW'(cy+1)];
  logic [16:0] iu, iv;
  assign iu = 17'(WEIGHT_ONE) - u;
  assign iv = 17'(WEIGHT_ONE) - v;
  logic [3:0] pass;   // 0 bx,1 by,2 wx,3 wy
  logic signed [33:0] p00, p10, p01, p11;
  always_comb begin
    unique case (pass[1:0])
      2'd0: begin p00 = 34'(ux0); p10 = 34'(ux1); p01 = 34'(ux0); p11 = 34'(ux1); end
      2'd1: begin p00 = 34'(uy0); p10 = 34'(uy0); p01 = 34'(uy1); p11 = 34'(uy1); end
      2'd2: begin
        p00 = 34'(ux0) + 34'(dfx[0]); p10 = 34'(ux1) + 34'(dfx[1]);
        p01 = 34'(ux0) + 34'(dfx[2]); p11 = 34'(ux1) + 34'(dfx[3]);
      end
      default: begin
        p00 = 34'(uy0) + 34'(dfy[0]); p10 = 34'(uy0) + 34'(dfy[1]);
        p01 = 34'(uy1) + 34'(dfy[2]); p11 = 34'(uy1) + 34'(dfy[3]);
      end
    endcase
    unique case (mstep)
      3'd0: begin mop = p00; mw = 18'(iu); end
      3'd1: begin mop = p10; mw = 18'(u); end
      3'd2: begin mop = p01; mw = 18'(iu); end
      3'd3: begin mop = p11; mw = 18'(u); end
      3'd4: begin mop = 34'(r0); mw = 18'(iv); end
      default: begin mop = 34'(r1); mw = 18'(v); end
    endcase
  end
  assign prod = 64'(mop) * 64'(mw);
  logic signed [63:0] accp;
  assign accp = acc + prod;

  assign out_ch.valid = out_valid;
  assign out_ch.data = res;

  always_comb begin
    state_next = state;
    pop = 1'b0;
    div_start = 1'b0;
    dwe = 1'b0;
    dwaddr = cmd.slot;
    dwx = cmd.value_x;
    dwy = cmd.value_y;
    draddr = DW'(vidx);
    unique case (state)
      ST_CLEAR: begin
        dwe = 1'b1; dwaddr = clr_addr; dwx = '0; dwy = '0;
        if (clr_addr == DW'(DEFORM_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (!empty) begin
          if (cmd.func == FUNC_SAMPLE) begin
            if (!out_valid || out_ch.ready) begin
              pop = 1'b1;
              state_next = (x_points < 5'd2 || y_points < 5'd2) ? ST_DONE : ST_SRCH;
            end
          end else begin
            pop = 1'b1;
            dwe = cmd.func == FUNC_LOAD_D;
          end
        end
      end
      ST_SRCH: begin
        if (pcl <= a_i1 || idx_i == last_i) begin
          div_start = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy && !div_pend) state_next = axis_sel ? ST_DFRD : ST_SRCH;
      end
      ST_DFRD: state_next = ST_DFWT;
      // last corner lands once corner has wrapped back to zero
      ST_DFWT: if (corner == 2'd0) state_next = ST_MUL;
      ST_MUL: if (mstep == 3'd5 && pass == 4'd3) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end
  assign div_num = (numd > 0 && span > 0) ? {numd[32:0], 16'd0} : '0;
  assign div_den = (span > 0) ? span : 33'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      div_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + DW'(1);
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      div_pend <= div_start;
      if (state == ST_DONE) out_valid <= 1'b1;
    end
    // axis tables and working registers
    if (state == ST_IDLE && !empty) begin
      if (cmd.func == FUNC_LOAD_X) ax[AW'(cmd.slot)] <= cmd.value_x;
      if (cmd.func == FUNC_LOAD_Y) ay[AW'(cmd.slot)] <= cmd.value_x;
    end
    unique case (state)
      ST_IDLE: begin
        nx <= (x_points > 5'(MAX_AXIS_POINTS)) ? (AW+1)'(MAX_AXIS_POINTS) : (AW+1)'(x_points);
        ny <= (y_points > 5'(MAX_AXIS_POINTS)) ? (AW+1)'(MAX_AXIS_POINTS) : (AW+1)'(y_points);
        px <= 33'(signed'(cmd.value_x));
        py <= 33'(signed'(cmd.value_y));
        idx_i <= '0;
        axis_sel <= 1'b0;
        corner <= '0;
        // a waiting result stays intact until a new sample is taken
        if (pop && cmd.func == FUNC_SAMPLE) res <= '0;
      end
      ST_SRCH: begin
        if (pcl <= a_i1 || idx_i == last_i) begin
          if (axis_sel) cy <= idx_i; else cx <= idx_i;
        end else idx_i <= idx_i + AW'(1);
      end
      ST_DIV: begin
        if (!div_busy && !div_pend) begin
          if (axis_sel) v <= snap(div_quo); else u <= snap(div_quo);
          axis_sel <= 1'b1;
          idx_i <= '0;
          corner <= '0;
        end
      end
      ST_DFRD: corner <= 2'd1;
      ST_DFWT: begin
        dfx[corner - 2'd1] <= drx;
        dfy[corner - 2'd1] <= dry;
        corner <= corner + 2'd1;
        mstep <= '0; pass <= '0; acc <= '0;
      end
      ST_MUL: begin
        if (mstep == 3'd1 || mstep == 3'd3 || mstep == 3'd5) begin
          acc <= '0;
          if (mstep == 3'd1) r0 <= accp >>> WEIGHT_SHIFT;
          if (mstep == 3'd3) r1 <= accp >>> WEIGHT_SHIFT;
          if (mstep == 3'd5) begin
            unique case (pass[1:0])
              2'd0: bx <= accp >>> WEIGHT_SHIFT;
              2'd1: by <= accp >>> WEIGHT_SHIFT;
              2'd2: wx <= accp >>> WEIGHT_SHIFT;
              default: begin
                res.valid_res <= 1'b1;
                res.cell_col <= 4'(cx);
                res.cell_row <= 4'(cy);
                res.weight_u <= u;
                res.weight_v <= v;
                res.warped_x <= sat32(wx);
                res.warped_y <= sat32(accp >>> WEIGHT_SHIFT);
                res.offset_x <= sat32(wx - bx);
                res.offset_y <= sat32((accp >>> WEIGHT_SHIFT) - by);
              end
            endcase
          end
        end else acc <= accp;
        if (mstep == 3'd5) begin
          mstep <= '0;
          pass <= pass + 4'd1;
        end else mstep <= mstep + 3'd1;
      end
      default: ;
    endcase
  end
  // corner k is addressed in the cycle before its read data is stored in dfx[k]
endmodule
